@@ sv/itsb_pkg.sv @@
// ----------------------------------------------------------------------------
// itsb_pkg
// shared types and constants of the interval timing statistics bank
// ----------------------------------------------------------------------------
package itsb_pkg;

    localparam int ITSB_NUM_COUNTERS = 32;

    localparam int FREQ_W  = 34;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int NS_W    = 30;

    localparam logic [NS_W-1:0]   NS_PER_SECOND   = NS_W'(1000000000);
    localparam logic [FREQ_W-1:0] DEFAULT_FREQ_HZ = FREQ_W'(2000000000);
    localparam logic [WORD_W-1:0] ALL_ONES        = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_START,
        CMD_END,
        CMD_RESET,
        CMD_STATS
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_DIV,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] calls;
        logic [WORD_W-1:0] total_ns;
        logic [WORD_W-1:0] max_ns;
        logic [WORD_W-1:0] min_ns;
    } stats_t;

    typedef struct packed {
        logic              active;
        logic [WORD_W-1:0] start_stamp;
    } timer_t;

    localparam stats_t STATS_RESET = '{
        calls:    '0,
        total_ns: '0,
        max_ns:   '0,
        min_ns:   ALL_ONES
    };

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ sv/itsb_div.sv @@
// ----------------------------------------------------------------------------
// itsb_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module itsb_div
    import itsb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W:0]   rem_reg;
    logic [WORD_W-1:0] quot_reg;
    logic [WORD_W-1:0] divisor_reg;

    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg[WORD_W-1:0], quot_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign fits      = !rem_diff[WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quot_reg    <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_diff : rem_shift;
            quot_reg <= {quot_reg[WORD_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

@@ sv/interval_timing_stats_bank.sv @@
// ----------------------------------------------------------------------------
// interval_timing_stats_bank
// bank of interval timers with call count, total, min, max and average
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries command, counter_index and
//   timestamp; each transfer yields exactly one result transfer on the output
//   channel (out_valid/out_ready) with status, call_count and average_ns
//   cfg_we/cfg_wdata writes the clock frequency in hz (zero means 2 ghz);
//   the user must write it only while the block is idle, which the block
//   itself does not enforce
//   one item is in work at a time; an invalid index goes straight to the
//   result; start, reset, an ignored end and a read of an empty counter end
//   after the memory read; an end stamped before its start skips the divide;
//   read statistics and end use the 64-step radix-2 divider shared by the
//   elapsed-time conversion and the average
//   per-counter state sits in two memories with a registered read (statistics
//   and timer); a valid bit per entry makes an unwritten entry read as its
//   reset value, so reset takes effect at once with no clearing pass
//   a finished result waits in the output register while the receiver
//   stalls; the block returns to idle and takes the next item once the
//   result is in that register
// ----------------------------------------------------------------------------
module interval_timing_stats_bank
    import itsb_pkg::*;
#(
    parameter int NUM_COUNTERS = ITSB_NUM_COUNTERS
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic [FREQ_W-1:0] cfg_wdata,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [7:0]        counter_index,
    input  logic [WORD_W-1:0] timestamp,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [WORD_W-1:0] call_count,
    output logic [WORD_W-1:0] average_ns
);

    localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam logic [8:0] NUM_LIMIT = 9'(NUM_COUNTERS);

    // configuration
    logic [FREQ_W-1:0] freq_reg;
    logic [WORD_W-1:0] freq_eff;

    // control
    state_t state_reg, state_next;

    // current item
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WORD_W-1:0] stamp_reg;
    logic              bad_reg;

    // memories and their read data
    stats_t stats_mem [NUM_COUNTERS];
    timer_t timer_mem [NUM_COUNTERS];
    stats_t stats_rd_reg;
    timer_t timer_rd_reg;
    logic [NUM_COUNTERS-1:0] stats_valid_reg;
    logic [NUM_COUNTERS-1:0] timer_valid_reg;

    // working registers
    stats_t            work_reg;
    logic [WORD_W-1:0] diff_reg;
    logic [WORD_W-1:0] prod_lo_reg;
    logic [HALF_W-1:0] prod_hi_reg;
    logic [WORD_W-1:0] elapsed_reg;
    logic [WORD_W-1:0] res_calls_reg;
    logic [WORD_W-1:0] res_avg_reg;

    // output register
    logic              out_valid_reg;
    logic              status_reg;
    logic [WORD_W-1:0] call_count_reg;
    logic [WORD_W-1:0] average_ns_reg;

    // combinational controls
    logic              in_fire;
    logic              idx_ok;
    logic              out_free;
    stats_t            stats_eff;
    timer_t            timer_eff;
    logic              early_stamp;
    logic              stats_we;
    stats_t            stats_wdata;
    logic              timer_we;
    timer_t            timer_wdata;
    logic              div_start;
    logic [WORD_W-1:0] div_dividend;
    logic [WORD_W-1:0] div_divisor;
    div_stat_t         div_stat;
    logic [WORD_W-1:0] div_quotient;
    logic              load_out;

    assign in_fire  = in_valid && in_ready;
    assign idx_ok   = {1'b0, counter_index} < NUM_LIMIT;
    assign out_free = !out_valid_reg || out_ready;

    // zero frequency selects the default
    assign freq_eff = (freq_reg == '0) ? WORD_W'(DEFAULT_FREQ_HZ) : WORD_W'(freq_reg);

    // entries never written read as reset values
    assign stats_eff   = stats_valid_reg[idx_reg] ? stats_rd_reg : STATS_RESET;
    assign timer_eff   = timer_valid_reg[idx_reg] ? timer_rd_reg : '0;
    assign early_stamp = stamp_reg < timer_eff.start_stamp;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
        end
        else if (cfg_we)
        begin
            freq_reg <= cfg_wdata;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = idx_ok ? ST_READ : ST_RESP;
                end
            end
            ST_READ:
            begin
                unique case (cmd_reg)
                    CMD_START: state_next = ST_RESP;
                    CMD_RESET: state_next = ST_RESP;
                    CMD_END:
                    begin
                        priority if (!timer_eff.active)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (early_stamp)
                        begin
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            state_next = ST_MUL_LO;
                        end
                    end
                    CMD_STATS:
                    begin
                        state_next = (stats_eff.calls == '0) ? ST_RESP : ST_DIV;
                    end
                endcase
            end
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_MUL_SUM;
            ST_MUL_SUM: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (cmd_reg == CMD_END) ? ST_UPDATE : ST_RESP;
                end
            end
            ST_UPDATE:  state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready     = 1'b0;
        stats_we     = 1'b0;
        timer_we     = 1'b0;
        timer_wdata  = '0;
        div_start    = 1'b0;
        div_dividend = stats_eff.total_ns;
        div_divisor  = stats_eff.calls;
        load_out     = 1'b0;
        stats_wdata.calls    = work_reg.calls + 1'b1;
        stats_wdata.total_ns = work_reg.total_ns + elapsed_reg;
        stats_wdata.max_ns   = (elapsed_reg > work_reg.max_ns) ? elapsed_reg : work_reg.max_ns;
        stats_wdata.min_ns   = (elapsed_reg < work_reg.min_ns) ? elapsed_reg : work_reg.min_ns;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                unique case (cmd_reg)
                    CMD_START:
                    begin
                        timer_we    = 1'b1;
                        timer_wdata = '{active: 1'b1, start_stamp: stamp_reg};
                    end
                    CMD_END:
                    begin
                        // end closes the interval
                        timer_we    = timer_eff.active;
                        timer_wdata = '{active: 1'b0, start_stamp: timer_eff.start_stamp};
                    end
                    CMD_RESET:
                    begin
                    end
                    CMD_STATS:
                    begin
                        div_start = (stats_eff.calls != '0);
                    end
                endcase
            end
            ST_MUL_SUM:
            begin
                div_start    = 1'b1;
                div_dividend = prod_lo_reg + {prod_hi_reg, {HALF_W{1'b0}}};
                div_divisor  = freq_eff;
            end
            ST_UPDATE:
            begin
                stats_we = 1'b1;
            end
            ST_RESP:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (stats_we)
        begin
            stats_mem[idx_reg] <= stats_wdata;
        end
        if (in_fire && idx_ok)
        begin
            stats_rd_reg <= stats_mem[counter_index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (timer_we)
        begin
            timer_mem[idx_reg] <= timer_wdata;
        end
        if (in_fire && idx_ok)
        begin
            timer_rd_reg <= timer_mem[counter_index[IDX_W-1:0]];
        end
    end

    // valid bits; the reset command drops the statistics entry back to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_valid_reg <= '0;
            timer_valid_reg <= '0;
        end
        else
        begin
            if (stats_we)
            begin
                stats_valid_reg[idx_reg] <= 1'b1;
            end
            else if ((state_reg == ST_READ) && (cmd_reg == CMD_RESET))
            begin
                stats_valid_reg[idx_reg] <= 1'b0;
            end
            if (timer_we)
            begin
                timer_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // item and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg       <= cmd_t'(command);
            idx_reg       <= counter_index[IDX_W-1:0];
            stamp_reg     <= timestamp;
            bad_reg       <= !idx_ok;
            res_calls_reg <= '0;
            res_avg_reg   <= '0;
        end
        if (state_reg == ST_READ)
        begin
            work_reg    <= stats_eff;
            diff_reg    <= stamp_reg - timer_eff.start_stamp;
            elapsed_reg <= '0;
            if (cmd_reg == CMD_STATS)
            begin
                res_calls_reg <= stats_eff.calls;
            end
        end
        // 64 by 30 product wrapped to 64 bits, in two halves
        if (state_reg == ST_MUL_LO)
        begin
            prod_lo_reg <= {{HALF_W{1'b0}}, diff_reg[HALF_W-1:0]} * NS_PER_SECOND;
        end
        if (state_reg == ST_MUL_HI)
        begin
            prod_hi_reg <= HALF_W'(diff_reg[WORD_W-1:HALF_W] * NS_PER_SECOND);
        end
        if ((state_reg == ST_DIV) && div_stat.done)
        begin
            if (cmd_reg == CMD_END)
            begin
                elapsed_reg <= div_quotient;
            end
            else
            begin
                res_avg_reg <= div_quotient;
            end
        end
    end

    itsb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // output register parts the result from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg     <= bad_reg;
            call_count_reg <= bad_reg ? '0 : res_calls_reg;
            average_ns_reg <= bad_reg ? '0 : res_avg_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign call_count = call_count_reg;
    assign average_ns = average_ns_reg;

endmodule

@@ sim/interval_timing_stats_bank_tb.sv @@
// ----------------------------------------------------------------------------
// interval_timing_stats_bank_tb
// self-checking bench for the interval timing statistics bank: a directed
// table of corner cases, then random start/end/reset/stats sequences under
// several clock frequency settings and idling patterns, every result checked
// against its table entry or a cycle-free model of the counter bank
// ----------------------------------------------------------------------------
module interval_timing_stats_bank_tb;

    import itsb_pkg::*;

    localparam int NUM_CTR      = ITSB_NUM_COUNTERS;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 125;
    localparam int GAP_MAX      = 90;     // longest sender gap, spans a whole end item
    localparam int SETTLE       = 80;     // covers a whole end item
    localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
    localparam int DIR_ROWS     = 26;

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    // one result transfer
    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] call_count;
        logic [WORD_W-1:0] average_ns;
    } timing_result_t;

    // one directed row; typed rows carry their result, others use the model
    typedef struct packed {
        cmd_t              cmd;
        logic [7:0]        idx;
        logic [WORD_W-1:0] stamp;
        logic              typed;
        logic              status;
        logic [WORD_W-1:0] calls;
        logic [WORD_W-1:0] avg;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
        // fresh counters read as zero
        '{CMD_STATS, 8'd0,   64'd0,    1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd31,  ONES,     1'b1, 1'b0, 64'd0, 64'd0},
        // invalid index, every command
        '{CMD_STATS, 8'd32,  64'd0,    1'b1, 1'b1, 64'd0, 64'd0},
        '{CMD_STATS, 8'd255, 64'd0,    1'b1, 1'b1, 64'd0, 64'd0},
        '{CMD_START, 8'd255, ONES,     1'b1, 1'b1, 64'd0, 64'd0},
        '{CMD_END,   8'd128, 64'd0,    1'b1, 1'b1, 64'd0, 64'd0},
        '{CMD_RESET, 8'd32,  64'd0,    1'b1, 1'b1, 64'd0, 64'd0},
        // end on a counter that never started is ignored
        '{CMD_END,   8'd0,   64'd500,  1'b1, 1'b0, 64'd0, 64'd0},
        // a 2000-tick span at the 2 ghz default is 1000 ns
        '{CMD_START, 8'd0,   64'd0,    1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_END,   8'd0,   64'd2000, 1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd0,   64'd0,    1'b1, 1'b0, 64'd1, 64'd1000},
        // end earlier than start counts as zero elapsed
        '{CMD_START, 8'd31,  ONES,     1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_END,   8'd31,  64'd0,    1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd31,  64'd0,    1'b1, 1'b0, 64'd1, 64'd0},
        // reset clears the statistics
        '{CMD_RESET, 8'd0,   64'd0,    1'b1, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd0,   64'd0,    1'b1, 1'b0, 64'd0, 64'd0},
        // full-span interval, product wraps
        '{CMD_START, 8'd5,   64'd0,    1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_END,   8'd5,   ONES,     1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd5,   64'd0,    1'b0, 1'b0, 64'd0, 64'd0},
        // reset keeps the running interval
        '{CMD_START, 8'd7,   64'd100,  1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_RESET, 8'd7,   64'd0,    1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_END,   8'd7,   64'd300,  1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_STATS, 8'd7,   64'd0,    1'b0, 1'b0, 64'd0, 64'd0},
        // a second start restarts the interval
        '{CMD_START, 8'd9,   64'd10,   1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_START, 8'd9,   64'd50,   1'b0, 1'b0, 64'd0, 64'd0},
        '{CMD_END,   8'd9,   64'd90,   1'b0, 1'b0, 64'd0, 64'd0}
    };

    // dut signals, known from time zero
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [FREQ_W-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        command = '0;
    logic [7:0]        counter_index = '0;
    logic [WORD_W-1:0] timestamp = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              status;
    logic [WORD_W-1:0] call_count;
    logic [WORD_W-1:0] average_ns;

    // model copy of the counter bank
    logic [WORD_W-1:0] bank_calls    [NUM_CTR];
    logic [WORD_W-1:0] bank_total_ns [NUM_CTR];
    logic [WORD_W-1:0] bank_max_ns   [NUM_CTR];
    logic [WORD_W-1:0] bank_min_ns   [NUM_CTR];
    logic [WORD_W-1:0] bank_start    [NUM_CTR];
    logic              bank_active   [NUM_CTR];
    logic [FREQ_W-1:0] bank_freq_hz;

    timing_result_t pending_results [$];

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    interval_timing_stats_bank i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .counter_index (counter_index),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .call_count    (call_count),
        .average_ns    (average_ns)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // applies one command to the model bank and returns its result
    function automatic timing_result_t predict_timing(cmd_t cmd, logic [7:0] idx,
                                                      logic [WORD_W-1:0] stamp);
        timing_result_t    res;
        int unsigned       n;
        logic [WORD_W-1:0] freq;
        logic [WORD_W-1:0] span_ns;
        res = '0;
        n = idx;
        if (n >= NUM_CTR)
        begin
            // out-of-range index: status only, no state change
            res.status = 1'b1;
        end
        else
        begin
            case (cmd)
                CMD_START:
                begin
                    bank_start[n]  = stamp;
                    bank_active[n] = 1'b1;
                end
                CMD_END:
                begin
                    if (bank_active[n])
                    begin
                        if (stamp < bank_start[n])
                            span_ns = '0;
                        else
                        begin
                            freq = (bank_freq_hz == '0) ? WORD_W'(DEFAULT_FREQ_HZ)
                                                        : WORD_W'(bank_freq_hz);
                            // product wraps to 64 bits before the divide
                            span_ns = ((stamp - bank_start[n]) * WORD_W'(NS_PER_SECOND)) / freq;
                        end
                        bank_calls[n]    = bank_calls[n] + 64'd1;
                        bank_total_ns[n] = bank_total_ns[n] + span_ns;
                        if (span_ns > bank_max_ns[n])
                            bank_max_ns[n] = span_ns;
                        if (span_ns < bank_min_ns[n])
                            bank_min_ns[n] = span_ns;
                        bank_active[n] = 1'b0;
                    end
                end
                CMD_RESET:
                begin
                    // start stamp and active flag stay
                    bank_calls[n]    = '0;
                    bank_total_ns[n] = '0;
                    bank_max_ns[n]   = '0;
                    bank_min_ns[n]   = ONES;
                end
                default:
                begin
                    res.call_count = bank_calls[n];
                    res.average_ns = (bank_calls[n] != '0) ? bank_total_ns[n] / bank_calls[n]
                                                           : '0;
                end
            endcase
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // present one item, hold it until the transfer, then queue its result
    task automatic drive_item(cmd_t cmd, logic [7:0] idx, logic [WORD_W-1:0] stamp,
                              logic typed, timing_result_t typed_res);
        timing_result_t res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        counter_index <= idx;
        timestamp     <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer at this edge
        res = predict_timing(cmd, idx, stamp);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // mostly start/end pairs on a few hot counters, with reads, resets
    // and random noise mixed in
    task automatic random_phase(int unsigned n_items);
        int unsigned       sent;
        logic [7:0]        idx;
        logic [WORD_W-1:0] t0;
        logic [WORD_W-1:0] span;
        int unsigned       pick;
        timing_result_t    none;
        none = '0;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, NUM_CTR - 1))
                                                  : 8'($urandom_range(0, 3));
                t0 = $urandom_range(0, 1) ? {32'd0, 32'($urandom)}
                                          : {32'($urandom), 32'($urandom)};
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    span = 64'($urandom_range(0, 5000));
                else if (pick < 85)
                    span = {32'd0, 32'($urandom)};
                else
                    span = {32'($urandom), 32'($urandom)};
                drive_item(CMD_START, idx, t0, 1'b0, none);
                sent++;
                if ($urandom_range(0, 9) == 0)
                begin
                    drive_item(CMD_RESET, idx, {32'($urandom), 32'($urandom)}, 1'b0, none);
                    sent++;
                end
                // wrap past the top gives an end earlier than start
                drive_item(CMD_END, idx, t0 + span, 1'b0, none);
                sent++;
                if ($urandom_range(0, 9) < 4)
                begin
                    drive_item(CMD_STATS, idx, {32'($urandom), 32'($urandom)}, 1'b0, none);
                    sent++;
                end
            end
            else
            begin
                drive_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           {32'($urandom), 32'($urandom)}, 1'b0, none);
                sent++;
            end
        end
    endtask

    // receiver side: random stalls per phase
    always @(posedge clk)
    begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        timing_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result, status", 64'(status), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", 64'(status), 64'(want.status));
                if (call_count !== want.call_count)
                    flag_mismatch("call_count", call_count, want.call_count);
                if (average_ns !== want.average_ns)
                    flag_mismatch("average_ns", average_ns, want.average_ns);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("interval_timing_stats_bank verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned       send_tab [PHASES];
        int unsigned       recv_tab [PHASES];
        logic [FREQ_W-1:0] freq_tab [PHASES];
        timing_result_t    row_res;
        send_tab = '{0, 56, 0, 36, 56, 36};
        recv_tab = '{0, 0, 56, 36, 0, 36};
        // default, extremes of the register, the top of the useful range, a round value
        freq_tab = '{34'd0, 34'd1, {FREQ_W{1'b1}}, 34'd10000000000, 34'd1000000000, 34'd0};
        freq_tab[PHASES-1] = {2'($urandom_range(0, 3)), 32'($urandom)};

        // model bank after reset
        bank_freq_hz = '0;
        for (int i = 0; i < NUM_CTR; i++)
        begin
            bank_calls[i]    = '0;
            bank_total_ns[i] = '0;
            bank_max_ns[i]   = '0;
            bank_min_ns[i]   = ONES;
            bank_start[i]    = '0;
            bank_active[i]   = 1'b0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset frequency, no idling
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row_res.status     = DIRECTED_ROWS[r].status;
            row_res.call_count = DIRECTED_ROWS[r].calls;
            row_res.average_ns = DIRECTED_ROWS[r].avg;
            drive_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].stamp,
                       DIRECTED_ROWS[r].typed, row_res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // frequency changes only with the block idle
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= freq_tab[p];
            @(posedge clk);
            cfg_we       <= 1'b0;
            bank_freq_hz  = freq_tab[p];
            send_idle_pct  = send_tab[p];
            recv_stall_pct = recv_tab[p];
            random_phase(PHASE_ITEMS);
        end

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("interval_timing_stats_bank verification clean");
        else
            $display("interval_timing_stats_bank verification failed");
        $finish;
    end

endmodule
